### src/ptag_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptag_pkg
// Shared constants, types and helper functions of the precedence-driven
// three-address generator.
// ----------------------------------------------------------------------------
package ptag_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W     = $clog2(STACK_DEPTH);
    localparam int NUM_W     = $clog2(MAX_RESULTS + 1);
    localparam int BUF_IDX_W = $clog2(MAX_RESULTS);

    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_ASSIGN = 8'h3D;
    localparam logic [7:0] CH_END    = 8'h24;

    localparam logic [7:0] TEMP_START_RESET = 8'd90;

    localparam logic [1:0] PREC_END    = 2'd0;
    localparam logic [1:0] PREC_ASSIGN = 2'd1;
    localparam logic [1:0] PREC_ADD    = 2'd2;
    localparam logic [1:0] PREC_MUL    = 2'd3;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] temp;
    } t_quad;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic push_operand;
        logic check;
        logic pop_right;
        logic pop_left;
        logic reduce;
        logic finish_op;
        logic load_result;
        logic load_error;
        logic adv_rd;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic tok_is_op;
        logic reduce_ok;
        logic n_zero;
        logic err;
        logic out_free;
        logic rd_last;
    } t_status;

    function automatic logic is_operator(input logic [7:0] c);
        return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_MUL) ||
               (c == CH_DIV) || (c == CH_ASSIGN) || (c == CH_END);
    endfunction

    function automatic logic [1:0] precedence(input logic [7:0] c);
        logic [1:0] p;
        case (c)
            CH_PLUS, CH_MINUS: p = PREC_ADD;
            CH_MUL, CH_DIV:    p = PREC_MUL;
            CH_ASSIGN:         p = PREC_ASSIGN;
            default:           p = PREC_END;
        endcase
        return p;
    endfunction

endpackage

### src/ptag_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptag_ctrl
// Sequencer: accepts a token, steps the datapath through each reduction
// (check, pop right, pop left, reduce) and drains the buffered quadruples.
// ----------------------------------------------------------------------------
module ptag_ctrl
    import ptag_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHECK,
        ST_POP_R,
        ST_POP_L,
        ST_REDUCE,
        ST_FINISH,
        ST_DRAIN_RD,
        ST_DRAIN_LD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid && r_in_ready) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (i_status.tok_is_op) begin
                    n_state = ST_CHECK;
                end else begin
                    o_cmd.push_operand = 1'b1;
                    n_state            = ST_FINISH;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                if (i_status.reduce_ok) begin
                    n_state = ST_POP_R;
                end else begin
                    o_cmd.finish_op = 1'b1;
                    n_state         = ST_FINISH;
                end
            end
            ST_POP_R: begin
                o_cmd.pop_right = 1'b1;
                n_state         = ST_POP_L;
            end
            ST_POP_L: begin
                o_cmd.pop_left = 1'b1;
                n_state        = ST_REDUCE;
            end
            ST_REDUCE: begin
                o_cmd.reduce = 1'b1;
                n_state      = ST_CHECK;
            end
            ST_FINISH: begin
                if (!i_status.n_zero) begin
                    n_state = ST_DRAIN_RD;
                end else if (!i_status.err) begin
                    n_state = ST_IDLE;
                end else if (i_status.out_free) begin
                    // error with no quadruple: one all-zero transaction
                    o_cmd.load_error = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            ST_DRAIN_RD: begin
                n_state = ST_DRAIN_LD;
            end
            ST_DRAIN_LD: begin
                if (i_status.out_free) begin
                    o_cmd.load_result = 1'b1;
                    if (i_status.rd_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        o_cmd.adv_rd = 1'b1;
                        n_state      = ST_DRAIN_RD;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_in_ready <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_in_ready <= (n_state == ST_IDLE);
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

### src/ptag_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptag_dp
// Datapath: operand and operator stacks, temporary counter, result buffer
// for one token's quadruples and the output register.
// ----------------------------------------------------------------------------
module ptag_dp
    import ptag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_cmd,
    output t_status    o_status,
    input  logic [7:0] i_token,
    input  logic       i_cfg_valid,
    input  logic [7:0] i_cfg_temp_name_start,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_quad_operator,
    output logic [7:0] o_left_operand,
    output logic [7:0] o_right_operand,
    output logic [7:0] o_temp_name,
    output logic       o_error,
    output logic       o_last
);

    logic [7:0] r_opnd_mem [STACK_DEPTH];
    logic [7:0] r_optr_mem [STACK_DEPTH];
    t_quad      r_buf_mem  [MAX_RESULTS];

    logic [7:0]           r_token;
    logic [7:0]           r_op;
    logic [7:0]           r_left,       n_left;
    logic [7:0]           r_right,      n_right;
    logic [CNT_W-1:0]     r_opnd_cnt,   n_opnd_cnt;
    logic [CNT_W-1:0]     r_optr_cnt,   n_optr_cnt;
    logic [7:0]           r_next_temp,  n_next_temp;
    logic [7:0]           r_temp_start;
    logic                 r_err,        n_err;
    logic [NUM_W-1:0]     r_n;
    logic [BUF_IDX_W-1:0] r_rd_ptr;
    logic [7:0]           r_opnd_rdata;
    logic [7:0]           r_optr_rdata;
    t_quad                r_buf_rdata;

    logic             r_out_valid;
    t_quad            r_out_quad;
    logic             r_out_err;
    logic             r_out_last;

    logic [CNT_W-1:0] opnd_top;
    logic [CNT_W-1:0] optr_top;
    logic             opnd_we;
    logic [7:0]       opnd_wdata;
    logic             optr_we;
    logic             opnd_full;
    logic             optr_full;
    logic             out_free;
    t_quad            new_quad;

    assign opnd_full = (r_opnd_cnt == CNT_W'(STACK_DEPTH));
    assign optr_full = (r_optr_cnt == CNT_W'(STACK_DEPTH));
    assign out_free  = !r_out_valid || i_out_ready;

    // stacks, temporary counter, error flag: pushes, pops, end-marker clear
    always_comb begin
        n_opnd_cnt  = r_opnd_cnt;
        n_optr_cnt  = r_optr_cnt;
        n_next_temp = r_next_temp;
        n_left      = r_left;
        n_right     = r_right;
        n_err       = r_err;
        opnd_we     = 1'b0;
        opnd_wdata  = r_token;
        optr_we     = 1'b0;

        if (i_cmd.accept) begin
            n_err = 1'b0;
        end
        if (i_cmd.push_operand) begin
            if (opnd_full) begin
                n_err = 1'b1;
            end else begin
                opnd_we    = 1'b1;
                n_opnd_cnt = r_opnd_cnt + CNT_W'(1);
            end
        end
        if (i_cmd.pop_right || i_cmd.pop_left) begin
            if (r_opnd_cnt == '0) begin
                n_err = 1'b1;
                if (i_cmd.pop_right) n_right = '0;
                else                 n_left  = '0;
            end else begin
                n_opnd_cnt = r_opnd_cnt - CNT_W'(1);
                if (i_cmd.pop_right) n_right = r_opnd_rdata;
                else                 n_left  = r_opnd_rdata;
            end
        end
        if (i_cmd.reduce) begin
            n_optr_cnt  = r_optr_cnt - CNT_W'(1);
            n_next_temp = r_next_temp - 8'd1;
            opnd_wdata  = r_next_temp;
            if (opnd_full) begin
                n_err = 1'b1;
            end else begin
                opnd_we    = 1'b1;
                n_opnd_cnt = r_opnd_cnt + CNT_W'(1);
            end
        end
        if (i_cmd.finish_op) begin
            if (r_token == CH_END) begin
                n_opnd_cnt  = '0;
                n_optr_cnt  = '0;
                n_next_temp = r_temp_start;
            end else if (optr_full) begin
                n_err = 1'b1;
            end else begin
                optr_we    = 1'b1;
                n_optr_cnt = r_optr_cnt + CNT_W'(1);
            end
        end
        if (i_cfg_valid) begin
            n_next_temp = i_cfg_temp_name_start;
        end
    end

    // read the entry just below the next count; while reducing, the operator
    // top moves down by one
    assign opnd_top = n_opnd_cnt - CNT_W'(1);
    assign optr_top = r_optr_cnt - (i_cmd.reduce ? CNT_W'(2) : CNT_W'(1));

    assign new_quad = '{op: r_op, left: r_left, right: r_right, temp: r_next_temp};

    always_ff @(posedge i_clk) begin
        if (opnd_we) begin
            r_opnd_mem[r_opnd_cnt[IDX_W-1:0]] <= opnd_wdata;
        end
        if (optr_we) begin
            r_optr_mem[r_optr_cnt[IDX_W-1:0]] <= r_token;
        end
        if (i_cmd.reduce) begin
            r_buf_mem[r_n[BUF_IDX_W-1:0]] <= new_quad;
        end
        r_opnd_rdata <= r_opnd_mem[opnd_top[IDX_W-1:0]];
        r_optr_rdata <= r_optr_mem[optr_top[IDX_W-1:0]];
        r_buf_rdata  <= r_buf_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_token <= i_token;
        end
        if (i_cmd.check) begin
            r_op <= r_optr_rdata;
        end
        r_left  <= n_left;
        r_right <= n_right;
        if (i_cmd.load_result) begin
            r_out_quad <= r_buf_rdata;
            r_out_err  <= r_err;
            r_out_last <= o_status.rd_last;
        end else if (i_cmd.load_error) begin
            r_out_quad <= '0;
            r_out_err  <= 1'b1;
            r_out_last <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opnd_cnt   <= '0;
            r_optr_cnt   <= '0;
            r_next_temp  <= TEMP_START_RESET;
            r_temp_start <= TEMP_START_RESET;
            r_err        <= 1'b0;
            r_n          <= '0;
            r_rd_ptr     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_opnd_cnt  <= n_opnd_cnt;
            r_optr_cnt  <= n_optr_cnt;
            r_next_temp <= n_next_temp;
            r_err       <= n_err;
            if (i_cfg_valid) begin
                r_temp_start <= i_cfg_temp_name_start;
            end
            if (i_cmd.accept) begin
                r_n      <= '0;
                r_rd_ptr <= '0;
            end else begin
                if (i_cmd.reduce) r_n      <= r_n + NUM_W'(1);
                if (i_cmd.adv_rd) r_rd_ptr <= r_rd_ptr + BUF_IDX_W'(1);
            end
            if (i_cmd.load_result || i_cmd.load_error) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_status.tok_is_op = is_operator(r_token);
        o_status.reduce_ok = (r_n < NUM_W'(MAX_RESULTS)) && (r_optr_cnt != '0) &&
                             (precedence(r_optr_rdata) >= precedence(r_token));
        o_status.n_zero    = (r_n == '0);
        o_status.err       = r_err;
        o_status.out_free  = out_free;
        o_status.rd_last   = (NUM_W'(r_rd_ptr) == (r_n - NUM_W'(1)));
    end

    assign o_out_valid     = r_out_valid;
    assign o_quad_operator = r_out_quad.op;
    assign o_left_operand  = r_out_quad.left;
    assign o_right_operand = r_out_quad.right;
    assign o_temp_name     = r_out_quad.temp;
    assign o_error         = r_out_err;
    assign o_last          = r_out_last;

endmodule

### src/precedence_three_address_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// precedence_three_address_generator
// Operator-precedence translator from a character stream to quadruples.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready, i_token): one character per
// transaction; operands, + - * / =, and '$' to close the expression.
// Output channel (o_out_valid / i_out_ready): one quadruple per transaction
// (operator, left, right, temporary) with error and last flags; a token that
// causes no quadruple and no error yields no transaction.
// Config channel (i_cfg_valid / o_cfg_ready): writes the first temporary
// name and reloads the temporary counter; always ready, write only while idle.
// Steps per token: an operand is pushed; an operator is checked against the
// operator stack top and each reduction runs check, pop right, pop left and
// push temporary; quadruples are buffered until the token is done so the
// error flag is known, then leave one at a time (buffer read, then load).
// The next token is accepted while the last quadruple waits in the output
// register. A stalled receiver holds the drain; nothing is dropped.
// Reset (synchronous, active low) empties both stacks and sets the first
// temporary to 'Z' (90); no clearing pass is needed.
// ----------------------------------------------------------------------------
module precedence_three_address_generator
    import ptag_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_token,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_quad_operator,
    output logic [7:0] o_left_operand,
    output logic [7:0] o_right_operand,
    output logic [7:0] o_temp_name,
    output logic       o_error,
    output logic       o_last,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_temp_name_start
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    ptag_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ptag_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_token               (i_token),
        .i_cfg_valid           (i_cfg_valid),
        .i_cfg_temp_name_start (i_cfg_temp_name_start),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_quad_operator       (o_quad_operator),
        .o_left_operand        (o_left_operand),
        .o_right_operand       (o_right_operand),
        .o_temp_name           (o_temp_name),
        .o_error               (o_error),
        .o_last                (o_last)
    );

endmodule

### tb/tb_precedence_three_address_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_precedence_three_address_generator
// Feeds token streams (a short directed expression set, then random
// expressions, noise and stack-overflow bursts) through the generator under
// random stalls on both channels. A local operator-precedence translator
// predicts every quadruple, and each output transaction is compared against
// the oldest prediction. The first temporary name is reprogrammed between
// phases.
// ----------------------------------------------------------------------------
module tb_precedence_three_address_generator;
    import ptag_pkg::*;

    localparam int PHASES         = 4;
    localparam int PHASE_ITEMS    = 120;
    localparam int SETTLE_CYCLES  = 100;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [7:0] op;
        logic [7:0] left;
        logic [7:0] right;
        logic [7:0] temp;
        logic       err;
        logic       last;
    } t_quad_rec;

    logic       i_clk;
    logic       i_rst_n               = 1'b0;
    logic       i_in_valid            = 1'b0;
    logic [7:0] i_token               = 8'd0;
    logic       i_out_ready           = 1'b0;
    logic       i_cfg_valid           = 1'b0;
    logic [7:0] i_cfg_temp_name_start = 8'd0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_quad_operator;
    logic [7:0] o_left_operand;
    logic [7:0] o_right_operand;
    logic [7:0] o_temp_name;
    logic       o_error;
    logic       o_last;
    logic       o_cfg_ready;

    // translator state
    logic [7:0] opnd_stk [STACK_DEPTH];
    logic [7:0] optr_stk [STACK_DEPTH];
    int         opnd_cnt   = 0;
    int         optr_cnt   = 0;
    logic [7:0] temp_start = TEMP_START_RESET;
    logic [7:0] temp_next  = TEMP_START_RESET;

    logic [7:0] token_feed [$];
    t_quad_rec  pending_quads [$];
    int         tokens_queued = 0;
    int         in_mode       = 2;
    int         out_mode      = 2;
    int         feed_gap      = 0;
    int         drain_gap     = 0;
    int         hold_left     = 0;
    int         quads_seen    = 0;
    int         failures      = 0;
    int         idle_cycles   = 0;

    precedence_three_address_generator u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (i_in_valid),
        .o_in_ready            (o_in_ready),
        .i_token               (i_token),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_quad_operator       (o_quad_operator),
        .o_left_operand        (o_left_operand),
        .o_right_operand       (o_right_operand),
        .o_temp_name           (o_temp_name),
        .o_error               (o_error),
        .o_last                (o_last),
        .i_cfg_valid           (i_cfg_valid),
        .o_cfg_ready           (o_cfg_ready),
        .i_cfg_temp_name_start (i_cfg_temp_name_start)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit tok_is_operator(input logic [7:0] c);
        return c == CH_PLUS || c == CH_MINUS || c == CH_MUL || c == CH_DIV ||
               c == CH_ASSIGN || c == CH_END;
    endfunction

    function automatic int tok_prec(input logic [7:0] c);
        case (c)
            CH_PLUS, CH_MINUS: return 2;
            CH_MUL, CH_DIV:    return 3;
            CH_ASSIGN:         return 1;
            default:           return 0;
        endcase
    endfunction

    function automatic logic [7:0] pop_operand(inout logic fault);
        if (opnd_cnt == 0) begin
            fault = 1'b1;
            return 8'd0;
        end
        opnd_cnt--;
        return opnd_stk[opnd_cnt];
    endfunction

    function automatic int draw_wait(input int mode);
        case (mode)
            0:       return 0;
            1:       return $urandom_range(0, 14);
            default: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
        endcase
    endfunction

    function automatic logic [7:0] rand_operand();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        while (tok_is_operator(c))
            c = 8'($urandom_range(0, 255));
        return c;
    endfunction

    function automatic logic [7:0] rand_operator();
        case ($urandom_range(0, 4))
            0:       return CH_PLUS;
            1:       return CH_MINUS;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_ASSIGN;
        endcase
    endfunction

    function automatic void queue_token(input logic [7:0] tok);
        token_feed.push_back(tok);
        tokens_queued++;
    endfunction

    // Reduce by precedence and append the quadruples this token produces.
    function automatic void translate_token(input logic [7:0] tok);
        t_quad_rec  quads [$];
        t_quad_rec  q;
        logic       fault;
        logic [7:0] rhs;
        logic [7:0] lhs;
        fault = 1'b0;
        if (!tok_is_operator(tok)) begin
            if (opnd_cnt < STACK_DEPTH) begin
                opnd_stk[opnd_cnt] = tok;
                opnd_cnt++;
            end else begin
                fault = 1'b1;
            end
        end else begin
            while (quads.size() < MAX_RESULTS && optr_cnt > 0 &&
                   tok_prec(optr_stk[optr_cnt - 1]) >= tok_prec(tok)) begin
                rhs = pop_operand(fault);
                lhs = pop_operand(fault);
                optr_cnt--;
                q = '{op: optr_stk[optr_cnt], left: lhs, right: rhs, temp: temp_next,
                      err: 1'b0, last: 1'b0};
                if (opnd_cnt < STACK_DEPTH) begin
                    opnd_stk[opnd_cnt] = temp_next;
                    opnd_cnt++;
                end else begin
                    fault = 1'b1;
                end
                temp_next = temp_next - 8'd1;
                quads.push_back(q);
            end
            if (tok == CH_END) begin
                opnd_cnt  = 0;
                optr_cnt  = 0;
                temp_next = temp_start;
            end else if (optr_cnt < STACK_DEPTH) begin
                optr_stk[optr_cnt] = tok;
                optr_cnt++;
            end else begin
                fault = 1'b1;
            end
        end
        // an error with no reduction still reports one all-zero quadruple
        if (quads.size() == 0 && fault)
            quads.push_back('0);
        foreach (quads[k]) begin
            quads[k].err  = fault;
            quads[k].last = (k == quads.size() - 1);
            pending_quads.push_back(quads[k]);
        end
    endfunction

    task automatic wait_idle();
        while (token_feed.size() != 0 || i_in_valid || pending_quads.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // token driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            feed_gap = 0;
        end else begin
            if (i_in_valid && o_in_ready)
                translate_token(i_token);
            if (!i_in_valid || o_in_ready) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                    i_in_valid <= 1'b0;
                end else if (token_feed.size() != 0) begin
                    i_in_valid <= 1'b1;
                    i_token    <= token_feed.pop_front();
                    feed_gap = draw_wait(in_mode);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // quadruple monitor
    always @(posedge i_clk) begin
        t_quad_rec want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            drain_gap = 0;
            hold_left = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_quads.size() == 0) begin
                    failures++;
                    if (failures <= REPORT_LIMIT)
                        $display("unexpected quadruple: %h %h %h %h err=%b last=%b",
                                 o_quad_operator, o_left_operand, o_right_operand,
                                 o_temp_name, o_error, o_last);
                end else begin
                    want = pending_quads.pop_front();
                    if (o_quad_operator !== want.op || o_left_operand !== want.left ||
                        o_right_operand !== want.right || o_temp_name !== want.temp ||
                        o_error !== want.err || o_last !== want.last) begin
                        failures++;
                        if (failures <= REPORT_LIMIT)
                            $display("mismatch: exp %h %h %h %h %b %b, got %h %h %h %h %b %b",
                                     want.op, want.left, want.right, want.temp, want.err,
                                     want.last, o_quad_operator, o_left_operand,
                                     o_right_operand, o_temp_name, o_error, o_last);
                    end
                end
                quads_seen++;
                // hold off long enough for the block to back up into its input
                if (quads_seen == 40 || quads_seen == 250)
                    hold_left = LONG_HOLD;
                drain_gap = draw_wait(out_mode);
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else if (drain_gap > 0) begin
                drain_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [7:0] cfg_plan [PHASES];
        int         in_plan  [PHASES];
        int         out_plan [PHASES];
        int         phase_end;
        int         kind;
        int         n;
        cfg_plan = '{8'h00, 8'hFF, 8'h00, 8'h01};
        cfg_plan[2] = 8'($urandom_range(0, 255));
        in_plan  = '{1, 0, 1, 2};
        out_plan = '{1, 1, 0, 2};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // leading assignment, every operator, operand underflow on '$'
        queue_token(CH_ASSIGN);
        queue_token("a");
        queue_token(CH_PLUS);
        queue_token("b");
        queue_token(CH_MUL);
        queue_token("c");
        queue_token(CH_MINUS);
        queue_token("d");
        queue_token(CH_DIV);
        queue_token(CH_END);
        // operand overflow with extreme codes, then '$' with nothing to reduce
        queue_token(8'h00);
        queue_token(8'hFF);
        for (int k = 0; k < STACK_DEPTH - 1; k++)
            queue_token(8'("e" + k));
        queue_token(CH_END);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            @(posedge i_clk);
            i_cfg_valid           <= 1'b1;
            i_cfg_temp_name_start <= cfg_plan[ph];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            i_cfg_valid <= 1'b0;
            temp_start = cfg_plan[ph];
            temp_next  = cfg_plan[ph];
            in_mode  = in_plan[ph];
            out_mode = out_plan[ph];

            // a phase may stop mid-expression so the reload lands on live state
            phase_end = tokens_queued + PHASE_ITEMS;
            while (tokens_queued < phase_end) begin
                kind = $urandom_range(0, 9);
                if (kind < 7) begin
                    n = $urandom_range(1, 7);
                    if ($urandom_range(0, 2) == 0) begin
                        queue_token(rand_operand());
                        queue_token(CH_ASSIGN);
                    end
                    queue_token(rand_operand());
                    for (int k = 1; k < n; k++) begin
                        queue_token(rand_operator());
                        queue_token(rand_operand());
                    end
                    queue_token(CH_END);
                end else if (kind == 7) begin
                    repeat ($urandom_range(1, 8)) queue_token(8'($urandom_range(0, 255)));
                end else if (kind == 8) begin
                    repeat ($urandom_range(2, 8))
                        queue_token($urandom_range(0, 1) ? rand_operand() : rand_operator());
                    queue_token(CH_END);
                end else begin
                    repeat ($urandom_range(STACK_DEPTH - 1, STACK_DEPTH + 3))
                        queue_token(rand_operand());
                    if ($urandom_range(0, 1))
                        queue_token(rand_operator());
                    queue_token(CH_END);
                end
            end
        end

        wait_idle();
        if (failures == 0 && pending_quads.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
src/ptag_pkg.sv
src/ptag_ctrl.sv
src/ptag_dp.sv
src/precedence_three_address_generator.sv
tb/tb_precedence_three_address_generator.sv
